### rtl/tls_pkg.sv
// tls_pkg: shared constants, codes and types of the text line splitter.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package tls_pkg;

   // Widths of the counters and of the line length
   localparam int COUNT_BITS  = 32;
   localparam int LINE_BITS   = 16;

   // One input beat causes at most this many result beats
   localparam int MAX_RESULTS = 3;
   localparam int RES_IDX_W   = 2;

   // Queue between front and back
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = 2;

   // Register port
   localparam int REG_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [2:0] REG_MAX_LEN   = 3'd0;
   localparam logic [2:0] REG_CR_END    = 3'd1;
   localparam logic [2:0] REG_LF_END    = 3'd2;
   localparam logic [2:0] REG_NUL_CHECK = 3'd3;
   localparam logic [2:0] REG_QUIET     = 3'd4;

   localparam logic [LINE_BITS-1:0] MAX_LEN_RESET = LINE_BITS'(4096);

   // Special characters
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_NUL = 8'h00;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_PLAIN = 2'd1,
      OP_SKIP  = 2'd2,
      OP_EOS   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_LINE  = 3'd0,
      KIND_EOL   = 3'd1,
      KIND_PLAIN = 3'd2,
      KIND_SKIP  = 3'd3,
      KIND_WARN  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      WARN_NONE    = 3'd0,
      WARN_LONG    = 3'd1,
      WARN_LONE_LF = 3'd2,
      WARN_LONE_CR = 3'd3,
      WARN_NUL     = 3'd4
   } warn_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] line_limit;
      logic                 cr_ends_line;
      logic                 lf_ends_line;
      logic                 nul_check_enable;
      logic                 quiet_warnings;
   } cfg_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           out_byte;
      logic [LINE_BITS-1:0] line_length;
      warn_type             warning;
   } result_type;

   // All results of one input beat, slot 0 first
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [RES_IDX_W-1:0]         count;
   } bundle_type;

endpackage

`default_nettype wire

### rtl/tls_if.sv
// tls_if: valid/ready channel interfaces of the text line splitter.
// Depends on tls_pkg for field widths.
`default_nettype none

interface tls_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     opcode;
   logic [7:0]                     data_byte;
   logic [tls_pkg::COUNT_BITS-1:0] count_value;

   modport source (output valid, opcode, data_byte, count_value, input ready);
   modport sink   (input valid, opcode, data_byte, count_value, output ready);
endinterface

interface tls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    kind;
   logic [7:0]                    out_byte;
   logic [tls_pkg::LINE_BITS-1:0] line_length;
   logic [2:0]                    warning;
   logic                          last_of_run;

   modport source (output valid, kind, out_byte, line_length, warning, last_of_run,
                   input ready);
   modport sink   (input valid, kind, out_byte, line_length, warning, last_of_run,
                   output ready);
endinterface

`default_nettype wire

### rtl/tls_front.sv
// tls_front: accepts input beats, runs the line framing state and writes the
// results of each beat as one bundle into the queue. Depends on tls_pkg, tls_if.
`default_nettype none

module tls_front (
   input  wire                 clock,
   input  wire                 reset,
   tls_req_if.sink             req,
   input  tls_pkg::cfg_type    cfg,
   input  wire                 nul_load,
   input  wire                 nul_value,
   input  wire                 fifo_full,
   output logic                push,
   output tls_pkg::bundle_type push_data
);

   logic                               prev_cr_ff, prev_cr_in;
   logic                               cr_held_ff, cr_held_in;
   logic [tls_pkg::LINE_BITS-1:0]      line_count_ff, line_count_in;
   logic [tls_pkg::COUNT_BITS-1:0]     plain_ff, plain_in;
   logic [tls_pkg::COUNT_BITS-1:0]     skip_ff, skip_in;
   logic [tls_pkg::COUNT_BITS-1:0]     skip_wait_ff, skip_wait_in;
   logic                               nul_armed_ff, nul_armed_in;

   logic                               accept;
   tls_pkg::op_type                    op;
   logic [7:0]                         b;
   logic [tls_pkg::RES_IDX_W-1:0]      n;
   logic [tls_pkg::RES_IDX_W-1:0]      cur_idx;
   logic                               cur_valid;
   logic                               cr_rel;
   logic                               lone;
   logic                               defer;
   logic                               is_lf_after_cr;
   logic [tls_pkg::LINE_BITS:0]        used;
   tls_pkg::bundle_type                bundle;

   assign req.ready      = !fifo_full;
   assign accept         = req.valid && !fifo_full;
   assign op             = tls_pkg::op_type'(req.opcode);
   assign b              = req.data_byte;
   assign is_lf_after_cr = (b == tls_pkg::CH_LF) && prev_cr_ff;

   // Framing state update and result build for one beat
   always_comb begin
      prev_cr_in    = prev_cr_ff;
      cr_held_in    = cr_held_ff;
      line_count_in = line_count_ff;
      plain_in      = plain_ff;
      skip_in       = skip_ff;
      skip_wait_in  = skip_wait_ff;
      nul_armed_in  = nul_armed_ff;
      bundle        = '0;
      n             = '0;
      cur_idx       = '0;
      cur_valid     = 1'b0;
      cr_rel        = 1'b0;
      lone          = 1'b0;
      defer         = 1'b0;
      used          = '0;

      if (nul_load) begin
         nul_armed_in = nul_value;
      end

      if (accept) begin
         unique case (op)
            tls_pkg::OP_DATA: begin
               if (is_lf_after_cr && cfg.cr_ends_line) begin
                  // LF of a CR LF pair whose CR already ended the line
                  if (cr_held_in) begin
                     bundle.slot[n] = '{tls_pkg::KIND_LINE, tls_pkg::CH_CR, '0,
                                        tls_pkg::WARN_NONE};
                     n             = n + 1'b1;
                     line_count_in = line_count_in + 1'b1;
                     cr_held_in    = 1'b0;
                  end
                  prev_cr_in = 1'b0;
                  if (plain_ff == '0 && skip_wait_ff != '0) begin
                     skip_in      = skip_wait_ff;
                     skip_wait_in = '0;
                  end
               end else if (plain_ff != '0) begin
                  // pass-through byte
                  if (cr_held_in) begin
                     bundle.slot[n] = '{tls_pkg::KIND_LINE, tls_pkg::CH_CR, '0,
                                        tls_pkg::WARN_NONE};
                     n             = n + 1'b1;
                     line_count_in = line_count_in + 1'b1;
                     cr_held_in    = 1'b0;
                  end
                  bundle.slot[n] = '{tls_pkg::KIND_PLAIN, b, '0, tls_pkg::WARN_NONE};
                  n          = n + 1'b1;
                  plain_in   = plain_ff - 1'b1;
                  prev_cr_in = 1'b0;
               end else begin
                  // a pending skip starts now unless an LF of CR LF comes first
                  if (skip_wait_ff != '0) begin
                     if (is_lf_after_cr) begin
                        defer = 1'b1;
                     end else begin
                        skip_in      = skip_wait_ff;
                        skip_wait_in = '0;
                     end
                  end
                  if (!defer && skip_in != '0) begin
                     bundle.slot[n] = '{tls_pkg::KIND_SKIP, b, '0, tls_pkg::WARN_NONE};
                     n       = n + 1'b1;
                     skip_in = skip_in - 1'b1;
                  end else begin
                     used = {1'b0, line_count_in} + {{tls_pkg::LINE_BITS{1'b0}}, cr_held_in};
                     if (is_lf_after_cr) begin
                        // LF closes a line held open by a CR
                        if (cr_held_in) begin
                           cr_held_in     = 1'b0;
                           bundle.slot[n] = '{tls_pkg::KIND_EOL, 8'h00, line_count_in,
                                              tls_pkg::WARN_NONE};
                           n              = n + 1'b1;
                           line_count_in  = '0;
                        end
                        prev_cr_in = 1'b0;
                     end else if (used >= {1'b0, cfg.line_limit}) begin
                        // overflow: close the line, drop this byte
                        if (cr_held_in) begin
                           bundle.slot[n] = '{tls_pkg::KIND_LINE, tls_pkg::CH_CR, '0,
                                              tls_pkg::WARN_NONE};
                           n             = n + 1'b1;
                           line_count_in = line_count_in + 1'b1;
                           cr_held_in    = 1'b0;
                        end
                        bundle.slot[n] = '{tls_pkg::KIND_EOL, 8'h00, line_count_in,
                                           tls_pkg::WARN_LONG};
                        n              = n + 1'b1;
                        line_count_in  = '0;
                        prev_cr_in     = (b == tls_pkg::CH_CR);
                     end else begin
                        lone   = prev_cr_ff && !cfg.quiet_warnings;
                        cr_rel = cr_held_in;
                        if (cr_held_in) begin
                           bundle.slot[n] = '{tls_pkg::KIND_LINE, tls_pkg::CH_CR, '0,
                                              tls_pkg::WARN_NONE};
                           n             = n + 1'b1;
                           line_count_in = line_count_in + 1'b1;
                           cr_held_in    = 1'b0;
                        end
                        if (b == tls_pkg::CH_CR) begin
                           if (cfg.cr_ends_line) begin
                              bundle.slot[n] = '{tls_pkg::KIND_EOL, 8'h00, line_count_in,
                                                 tls_pkg::WARN_NONE};
                              n             = n + 1'b1;
                              line_count_in = '0;
                              lone          = 1'b0;
                           end else begin
                              cr_held_in = 1'b1;
                           end
                           prev_cr_in = 1'b1;
                        end else if (b == tls_pkg::CH_LF) begin
                           if (cfg.lf_ends_line) begin
                              bundle.slot[n] = '{tls_pkg::KIND_EOL, 8'h00, line_count_in,
                                                 tls_pkg::WARN_NONE};
                              n             = n + 1'b1;
                              line_count_in = '0;
                           end else begin
                              cur_valid      = 1'b1;
                              cur_idx        = n;
                              bundle.slot[n] = '{tls_pkg::KIND_LINE, b, '0,
                                                 cfg.quiet_warnings ? tls_pkg::WARN_NONE
                                                                    : tls_pkg::WARN_LONE_LF};
                              n             = n + 1'b1;
                              line_count_in = line_count_in + 1'b1;
                           end
                           prev_cr_in = 1'b0;
                        end else if (b == tls_pkg::CH_NUL && nul_armed_ff) begin
                           nul_armed_in = 1'b0;
                           if (!cfg.quiet_warnings) begin
                              bundle.slot[n] = '{tls_pkg::KIND_WARN, 8'h00, '0,
                                                 tls_pkg::WARN_NUL};
                              n = n + 1'b1;
                           end
                           prev_cr_in = 1'b0;
                        end else begin
                           cur_valid      = 1'b1;
                           cur_idx        = n;
                           bundle.slot[n] = '{tls_pkg::KIND_LINE, b, '0, tls_pkg::WARN_NONE};
                           n             = n + 1'b1;
                           line_count_in = line_count_in + 1'b1;
                           prev_cr_in    = 1'b0;
                        end
                        // lone CR warning rides on the released CR, else this byte
                        if (lone) begin
                           if (cr_rel) begin
                              bundle.slot[0].warning = tls_pkg::WARN_LONE_CR;
                           end else if (cur_valid) begin
                              bundle.slot[cur_idx].warning = tls_pkg::WARN_LONE_CR;
                           end else begin
                              bundle.slot[n] = '{tls_pkg::KIND_WARN, 8'h00, '0,
                                                 tls_pkg::WARN_LONE_CR};
                              n = n + 1'b1;
                           end
                        end
                     end
                     if (defer) begin
                        skip_in      = skip_wait_ff;
                        skip_wait_in = '0;
                     end
                  end
               end
            end
            tls_pkg::OP_PLAIN: begin
               plain_in = req.count_value;
            end
            tls_pkg::OP_SKIP: begin
               if (prev_cr_ff) begin
                  skip_wait_in = req.count_value;
               end else begin
                  skip_in      = req.count_value;
                  skip_wait_in = '0;
               end
            end
            tls_pkg::OP_EOS: begin
               // close an open line; a held CR counts as the CR of CR LF
               if (line_count_ff != '0 || cr_held_ff) begin
                  cr_held_in     = 1'b0;
                  bundle.slot[n] = '{tls_pkg::KIND_EOL, 8'h00, line_count_ff,
                                     tls_pkg::WARN_NONE};
                  n              = n + 1'b1;
                  line_count_in  = '0;
               end
               prev_cr_in = 1'b0;
            end
         endcase
      end
      bundle.count = n;
   end

   assign push      = accept && (n != '0);
   assign push_data = bundle;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cr_ff    <= 1'b0;
         cr_held_ff    <= 1'b0;
         line_count_ff <= '0;
         plain_ff      <= '0;
         skip_ff       <= '0;
         skip_wait_ff  <= '0;
         nul_armed_ff  <= 1'b0;
      end else begin
         prev_cr_ff    <= prev_cr_in;
         cr_held_ff    <= cr_held_in;
         line_count_ff <= line_count_in;
         plain_ff      <= plain_in;
         skip_ff       <= skip_in;
         skip_wait_ff  <= skip_wait_in;
         nul_armed_ff  <= nul_armed_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tls_fifo.sv
// tls_fifo: short queue of result bundles between front and back.
// Depends on tls_pkg.
`default_nettype none

module tls_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  tls_pkg::bundle_type push_data,
   output logic                full,
   input  wire                 pop,
   output tls_pkg::bundle_type pop_data,
   output logic                empty
);

   tls_pkg::bundle_type               mem_ff [tls_pkg::FIFO_DEPTH];
   logic [tls_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tls_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tls_pkg::FIFO_PTR_W:0]      level_ff, level_in;

   assign full     = (level_ff == (tls_pkg::FIFO_PTR_W + 1)'(tls_pkg::FIFO_DEPTH));
   assign empty    = (level_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + {{tls_pkg::FIFO_PTR_W{1'b0}}, push}
                           - {{tls_pkg::FIFO_PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/tls_back.sv
// tls_back: takes bundles from the queue and sends their results one beat at a
// time through an output register. Depends on tls_pkg, tls_if.
`default_nettype none

module tls_back (
   input  wire                 clock,
   input  wire                 reset,
   input  tls_pkg::bundle_type head,
   input  wire                 empty,
   output logic                pop,
   tls_rsp_if.source           rsp
);

   logic                           busy_ff, busy_in;
   logic [tls_pkg::RES_IDX_W-1:0]  idx_ff, idx_in;
   tls_pkg::bundle_type            hold_ff, hold_in;
   logic                           out_valid_ff, out_valid_in;
   tls_pkg::result_type            out_ff, out_in;
   logic                           out_last_ff, out_last_in;
   logic                           load;
   logic                           last;

   assign load = !out_valid_ff || rsp.ready;

   // Pick the next result: rest of a held bundle first, else the queue head
   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      hold_in      = hold_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      last         = 1'b0;
      if (load) begin
         if (busy_ff) begin
            last         = (idx_ff == hold_ff.count - 1'b1);
            out_in       = hold_ff.slot[idx_ff];
            out_last_in  = last;
            out_valid_in = 1'b1;
            busy_in      = !last;
            idx_in       = idx_ff + 1'b1;
         end else if (!empty) begin
            last         = (head.count == (tls_pkg::RES_IDX_W)'(1));
            pop          = 1'b1;
            out_in       = head.slot[0];
            out_last_in  = last;
            out_valid_in = 1'b1;
            if (!last) begin
               hold_in = head;
               busy_in = 1'b1;
               idx_in  = (tls_pkg::RES_IDX_W)'(1);
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_ff.kind;
   assign rsp.out_byte    = out_ff.out_byte;
   assign rsp.line_length = out_ff.line_length;
   assign rsp.warning     = out_ff.warning;
   assign rsp.last_of_run = out_last_ff;

endmodule

`default_nettype wire

### rtl/text_line_splitter.sv
// text_line_splitter: top level with the register port, front, queue and back.
// Depends on tls_pkg, tls_if, tls_front, tls_fifo, tls_back.
//
// Use: stream beats arrive on req_ch (opcode, data_byte, count_value) and
// results leave on rsp_ch (kind, out_byte, line_length, warning, last_of_run),
// both valid/ready. Each input beat gives zero to three result beats; the
// last of them carries last_of_run. Registers sit on the APB-style port at
// byte addresses 0,4,8,12,16. The user must write them only while the block
// is idle; the block itself does not enforce it. Throughput: one input beat
// per cycle while the queue has room, and one result beat per cycle on the
// output while the receiver is ready; beats with two or three results send
// them one after another, and the four-entry bundle queue absorbs them.
// The first result of an input beat is written into the queue at the edge
// that accepts the beat, then into the output register that drives rsp_ch.
// Reset: synchronous, active high; clears the line state, counters and queue
// and loads the register defaults (max length 4096, CR and LF end lines).
// When the receiver stalls, the output register holds its beat, the queue
// fills, and req_ch.ready drops once the queue is full.
`default_nettype none

module text_line_splitter (
   input  wire                              clock,
   input  wire                              reset,
   tls_req_if.sink                          req_ch,
   tls_rsp_if.source                        rsp_ch,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [tls_pkg::REG_ADDR_W-1:0]    paddr,
   input  wire [tls_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tls_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   tls_pkg::cfg_type    cfg_ff, cfg_in;
   logic                wr_en;
   logic [2:0]          reg_idx;
   logic                nul_load;
   logic                fifo_full;
   logic                fifo_empty;
   logic                push;
   logic                pop;
   tls_pkg::bundle_type push_data;
   tls_pkg::bundle_type head;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite;
   assign reg_idx  = paddr[4:2];
   assign nul_load = wr_en && (reg_idx == tls_pkg::REG_NUL_CHECK);

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tls_pkg::REG_MAX_LEN:   cfg_in.line_limit       = pwdata[tls_pkg::LINE_BITS-1:0];
            tls_pkg::REG_CR_END:    cfg_in.cr_ends_line     = pwdata[0];
            tls_pkg::REG_LF_END:    cfg_in.lf_ends_line     = pwdata[0];
            tls_pkg::REG_NUL_CHECK: cfg_in.nul_check_enable = pwdata[0];
            tls_pkg::REG_QUIET:     cfg_in.quiet_warnings   = pwdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_limit       <= tls_pkg::MAX_LEN_RESET;
         cfg_ff.cr_ends_line     <= 1'b1;
         cfg_ff.lf_ends_line     <= 1'b1;
         cfg_ff.nul_check_enable <= 1'b0;
         cfg_ff.quiet_warnings   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (reg_idx)
         tls_pkg::REG_MAX_LEN:
            prdata = {{(tls_pkg::CSR_DATA_W-tls_pkg::LINE_BITS){1'b0}}, cfg_ff.line_limit};
         tls_pkg::REG_CR_END:    prdata = {31'b0, cfg_ff.cr_ends_line};
         tls_pkg::REG_LF_END:    prdata = {31'b0, cfg_ff.lf_ends_line};
         tls_pkg::REG_NUL_CHECK: prdata = {31'b0, cfg_ff.nul_check_enable};
         tls_pkg::REG_QUIET:     prdata = {31'b0, cfg_ff.quiet_warnings};
         default:                prdata = '0;
      endcase
   end

   tls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg       (cfg_ff),
      .nul_load  (nul_load),
      .nul_value (pwdata[0]),
      .fifo_full (fifo_full),
      .push      (push),
      .push_data (push_data)
   );

   tls_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (fifo_empty)
   );

   tls_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (fifo_empty),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire
